@@ design/rwsc_pkg.sv @@
package rwsc_pkg;

    localparam int WORD_W = 32;
    localparam int SIZE_W = 26;
    localparam int OUT_OFFSET_W = 26;
    localparam int CRC_W = 16;
    localparam int KIND_W = 3;

    localparam logic [WORD_W-1:0] SYNC_WORD = 32'h1234_abcd;
    localparam logic [WORD_W-1:0] FILL_WORD = 32'hdead_beef;
    localparam logic [CRC_W-1:0]  CRC_INIT  = 16'hc387;
    localparam logic [CRC_W-1:0]  CRC_POLY  = 16'hc37b;

    typedef enum logic [KIND_W-1:0] {
        KIND_SYNC     = 3'd0,
        KIND_SIZE     = 3'd1,
        KIND_SIZE_CRC = 3'd2,
        KIND_DATA     = 3'd3,
        KIND_DATA_CRC = 3'd4,
        KIND_FILL     = 3'd5
    } kind_t;

    typedef struct packed {
        logic [WORD_W-1:0]       link_word;
        kind_t                   word_kind;
        logic [OUT_OFFSET_W-1:0] read_offset;
    } result_t;

endpackage

@@ design/rwsc_crc.sv @@
module rwsc_crc (
    input  logic [rwsc_pkg::CRC_W-1:0]  crc_in,
    input  logic [rwsc_pkg::WORD_W-1:0] data_in,
    output logic [rwsc_pkg::CRC_W-1:0]  crc_out
);

    logic [rwsc_pkg::CRC_W-1:0] crc_v;

    // the AND of crc and data bit is intentional; the peer computes it this way
    always_comb
    begin
        crc_v = crc_in;
        for (int i = 0; i < rwsc_pkg::WORD_W; i++)
        begin
            if (crc_v[0] & data_in[i])
            begin
                crc_v = {1'b0, crc_v[rwsc_pkg::CRC_W-1:1]} ^ rwsc_pkg::CRC_POLY;
            end
            else
            begin
                crc_v = {1'b0, crc_v[rwsc_pkg::CRC_W-1:1]};
            end
        end
    end

    assign crc_out = crc_v;

endmodule

@@ design/rwsc_seq.sv @@
module rwsc_seq #(
    parameter int OFFSET_BITS = 26
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [rwsc_pkg::SIZE_W-1:0]  cfg_wr_data,
    input  logic                         step,
    input  logic [rwsc_pkg::WORD_W-1:0]  rom_word,
    output rwsc_pkg::result_t            result
);

    localparam int CNT_W = OFFSET_BITS + 1;
    localparam int CMP_W = (CNT_W > rwsc_pkg::SIZE_W) ? CNT_W : rwsc_pkg::SIZE_W;

    typedef enum logic [2:0] {
        PH_SYNC,
        PH_SIZE,
        PH_SIZE_CRC,
        PH_DATA,
        PH_DATA_CRC,
        PH_FILL
    } phase_t;

    phase_t                       phase_reg, phase_next;
    logic [OFFSET_BITS-1:0]       count_reg, count_next;
    logic [rwsc_pkg::CRC_W-1:0]   crc_reg, crc_next;
    logic [rwsc_pkg::SIZE_W-1:0]  image_size_reg;

    logic [CNT_W-1:0]             count_inc;
    logic [rwsc_pkg::CRC_W-1:0]   crc_seed;
    logic [rwsc_pkg::WORD_W-1:0]  crc_data;
    logic [rwsc_pkg::CRC_W-1:0]   crc_calc;

    // one CRC unit shared between the size check and the data words
    assign crc_seed = (phase_reg == PH_SIZE_CRC) ? rwsc_pkg::CRC_INIT : crc_reg;
    assign crc_data = (phase_reg == PH_SIZE_CRC) ? rwsc_pkg::WORD_W'(image_size_reg)
                                                 : rom_word;

    rwsc_crc u_crc (
        .crc_in  (crc_seed),
        .data_in (crc_data),
        .crc_out (crc_calc)
    );

    assign count_inc = {1'b0, count_reg} + CNT_W'(4);

    always_comb
    begin
        phase_next         = phase_reg;
        count_next         = count_reg;
        crc_next           = crc_reg;
        result.link_word   = rwsc_pkg::FILL_WORD;
        result.word_kind   = rwsc_pkg::KIND_FILL;
        case (phase_reg)
            PH_SYNC:
            begin
                result.link_word = rwsc_pkg::SYNC_WORD;
                result.word_kind = rwsc_pkg::KIND_SYNC;
                phase_next       = PH_SIZE;
            end
            PH_SIZE:
            begin
                result.link_word = rwsc_pkg::WORD_W'(image_size_reg);
                result.word_kind = rwsc_pkg::KIND_SIZE;
                phase_next       = PH_SIZE_CRC;
            end
            PH_SIZE_CRC:
            begin
                result.link_word = rwsc_pkg::WORD_W'(crc_calc);
                result.word_kind = rwsc_pkg::KIND_SIZE_CRC;
                crc_next         = rwsc_pkg::CRC_INIT;
                phase_next       = PH_DATA;
            end
            PH_DATA:
            begin
                result.link_word = rom_word;
                result.word_kind = rwsc_pkg::KIND_DATA;
                crc_next         = crc_calc;
                // offset wraps at the top of the offset space and ends the data run
                if (count_inc[OFFSET_BITS])
                begin
                    count_next = '0;
                    phase_next = PH_DATA_CRC;
                end
                else
                begin
                    count_next = count_inc[OFFSET_BITS-1:0];
                    if (CMP_W'(count_inc) >= CMP_W'(image_size_reg))
                    begin
                        phase_next = PH_DATA_CRC;
                    end
                end
            end
            PH_DATA_CRC:
            begin
                result.link_word = rwsc_pkg::WORD_W'(crc_reg);
                result.word_kind = rwsc_pkg::KIND_DATA_CRC;
                phase_next       = PH_FILL;
            end
            default:
            begin
                result.link_word = rwsc_pkg::FILL_WORD;
                result.word_kind = rwsc_pkg::KIND_FILL;
            end
        endcase
        result.read_offset = rwsc_pkg::OUT_OFFSET_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SYNC;
            count_reg      <= '0;
            crc_reg        <= rwsc_pkg::CRC_INIT;
            image_size_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                image_size_reg <= cfg_wr_data;
            end
            if (step)
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                crc_reg   <= crc_next;
            end
        end
    end

endmodule

@@ design/rwsc_oreg.sv @@
module rwsc_oreg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rwsc_pkg::result_t push_data,
    output logic              push_ready,
    output logic              pop_valid,
    input  logic              pop_ready,
    output rwsc_pkg::result_t pop_data
);

    logic              main_valid_reg;
    logic              skid_valid_reg;
    rwsc_pkg::result_t main_reg;
    rwsc_pkg::result_t skid_reg;
    logic              pop;

    assign pop        = main_valid_reg & pop_ready;
    assign push_ready = !skid_valid_reg;
    assign pop_valid  = main_valid_reg;
    assign pop_data   = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else if (!push)
            begin
                main_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
    end

    // payload: no reset
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_reg <= skid_reg;
            end
            else if (push)
            begin
                main_reg <= push_data;
            end
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                skid_reg <= push_data;
            end
            else
            begin
                main_reg <= push_data;
            end
        end
    end

endmodule

@@ design/rom_image_word_sender_crc.sv @@
// channel   dir  handshake              payload
// request   in   in_valid / in_ready    rom_word[31:0]
// result    out  out_valid / out_ready  link_word[31:0], word_kind[2:0], read_offset[25:0]
// config    in   cfg_wr_en              cfg_wr_data[25:0] (image_size)
//
// One request per cycle unless stalled; its result is registered.
// The running CRC (32 rounds, unrolled) is the path from rom_word to the state registers.
// A two-entry output buffer keeps in_ready registered; requests stall only when both
// entries hold results not yet taken.
// Reset clears the sequence to the sync word and image_size to zero.
module rom_image_word_sender_crc #(
    parameter int OFFSET_BITS = 26
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [rwsc_pkg::SIZE_W-1:0]        cfg_wr_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [rwsc_pkg::WORD_W-1:0]        rom_word,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [rwsc_pkg::WORD_W-1:0]        link_word,
    output logic [rwsc_pkg::KIND_W-1:0]        word_kind,
    output logic [rwsc_pkg::OUT_OFFSET_W-1:0]  read_offset
);

    logic              step;
    rwsc_pkg::result_t seq_result;
    rwsc_pkg::result_t out_result;

    assign step = in_valid & in_ready;

    rwsc_seq #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (step),
        .rom_word    (rom_word),
        .result      (seq_result)
    );

    rwsc_oreg u_oreg (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (step),
        .push_data  (seq_result),
        .push_ready (in_ready),
        .pop_valid  (out_valid),
        .pop_ready  (out_ready),
        .pop_data   (out_result)
    );

    assign link_word   = out_result.link_word;
    assign word_kind   = out_result.word_kind;
    assign read_offset = out_result.read_offset;

    // a full skid entry implies the main entry is full
    a_skid_implies_main: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result pending");

    a_request_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid)
        else $error("accepted request produced no result");

    // nothing is read from ROM before the data run
    a_offset_zero_before_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (word_kind == rwsc_pkg::KIND_SYNC || word_kind == rwsc_pkg::KIND_SIZE
                       || word_kind == rwsc_pkg::KIND_SIZE_CRC)) |-> (read_offset == '0))
        else $error("offset advanced before data words");

endmodule
